/* sv/thst_pkg.sv */
`timescale 1ns / 1ps

package thst_pkg;

    localparam int MENU_ENTRIES = 5;
    localparam int MENU_W       = 3;
    localparam int SP_W         = 9;
    localparam int ADC_W        = 12;
    localparam int EV_W         = 3;

    localparam logic [SP_W-1:0] SETPOINT_MAX   = 9'd511;
    localparam logic [SP_W-1:0] TARGET_RESET   = 9'd32;
    localparam logic [SP_W-1:0] HIGH_RESET     = 9'd37;
    localparam logic [SP_W-1:0] LOW_RESET      = 9'd25;
    localparam logic [SP_W-1:0] TEMP_RESET     = 9'd34;
    localparam logic [8:0]      ADC_SCALE      = 9'd330;
    localparam int              ADC_SHIFT      = 12;
    localparam logic [5:0]      LAST_SEC_MIN   = 6'd59;
    localparam logic [4:0]      LAST_HOUR      = 5'd23;

    localparam logic [MENU_W-1:0] POS_TARGET = 3'd0;
    localparam logic [MENU_W-1:0] POS_HIGH   = 3'd1;
    localparam logic [MENU_W-1:0] POS_LOW    = 3'd2;

    typedef enum logic [EV_W-1:0] {
        EV_SAMPLE = 3'd0,
        EV_OK     = 3'd1,
        EV_UP     = 3'd2,
        EV_DOWN   = 3'd3,
        EV_TICK   = 3'd4
    } thst_event_t;

    typedef struct packed {
        logic [EV_W-1:0]  req_type;
        logic [ADC_W-1:0] adc_sample;
    } thst_req_t;

    typedef struct packed {
        logic [1:0]        cooling_level;
        logic [1:0]        heating_level;
        logic              alarm_on;
        logic              beep;
        logic              editing;
        logic [MENU_W-1:0] menu_item_index;
        logic [SP_W-1:0]   edited_value;
        logic [SP_W-1:0]   temperature;
        logic [4:0]        hours;
        logic [5:0]        minutes;
        logic [5:0]        seconds;
    } thst_rsp_t;

endpackage

/* sv/thst_req_if.sv */
`timescale 1ns / 1ps

interface thst_req_if;
    import thst_pkg::*;

    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  req_type;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output req_type, output adc_sample, input ready);
    modport sink (input valid, input req_type, input adc_sample, output ready);
endinterface

/* sv/thst_rsp_if.sv */
`timescale 1ns / 1ps

interface thst_rsp_if;
    import thst_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        cooling_level;
    logic [1:0]        heating_level;
    logic              alarm_on;
    logic              beep;
    logic              editing;
    logic [MENU_W-1:0] menu_item_index;
    logic [SP_W-1:0]   edited_value;
    logic [SP_W-1:0]   temperature;
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;

    modport source (
        output valid, output cooling_level, output heating_level, output alarm_on,
        output beep, output editing, output menu_item_index, output edited_value,
        output temperature, output hours, output minutes, output seconds,
        input ready
    );
    modport sink (
        input valid, input cooling_level, input heating_level, input alarm_on,
        input beep, input editing, input menu_item_index, input edited_value,
        input temperature, input hours, input minutes, input seconds,
        output ready
    );
endinterface

/* sv/thst_in_reg.sv */
`timescale 1ns / 1ps

module thst_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  thst_pkg::thst_req_t in_item,
    input  logic              advance,
    output logic              held_valid,
    output thst_pkg::thst_req_t held_item
);
    import thst_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    thst_req_t item_reg;

    // A held beat leaves on advance, so a new beat may enter in the same cycle.
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;
endmodule

/* sv/thst_core.sv */
`timescale 1ns / 1ps

module thst_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  thst_pkg::thst_req_t item,
    output thst_pkg::thst_rsp_t result
);
    import thst_pkg::*;

    logic              edit_mode_reg, edit_mode_next;
    logic [MENU_W-1:0] menu_pos_reg, menu_pos_next;
    logic [SP_W-1:0]   target_reg, target_next;
    logic [SP_W-1:0]   high_reg, high_next;
    logic [SP_W-1:0]   low_reg, low_next;
    logic [1:0]        cool_reg, cool_next;
    logic [1:0]        heat_reg, heat_next;
    logic [SP_W-1:0]   temp_reg, temp_next;
    logic [5:0]        sec_reg, sec_next;
    logic [5:0]        min_reg, min_next;
    logic [4:0]        hour_reg, hour_next;

    logic                    beep;
    logic [ADC_W+8:0]        product;
    logic [SP_W-1:0]         sample_temp;
    logic signed [SP_W+1:0]  diff;
    logic [MENU_W:0]         pos_inc;
    logic [SP_W-1:0]         sel_value;
    logic [SP_W-1:0]         sel_next_value;
    thst_event_t             ev;

    assign ev          = thst_event_t'(item.req_type);
    assign product     = (ADC_W+9)'(item.adc_sample) * (ADC_W+9)'(ADC_SCALE);
    assign sample_temp = product[ADC_SHIFT+SP_W-1:ADC_SHIFT];
    assign diff        = $signed({2'b00, sample_temp}) - $signed({2'b00, target_reg});
    assign pos_inc     = {1'b0, menu_pos_reg} + 1'b1;

    always_comb
    begin
        unique case (menu_pos_reg)
            POS_TARGET: sel_value = target_reg;
            POS_HIGH:   sel_value = high_reg;
            POS_LOW:    sel_value = low_reg;
            default:    sel_value = '0;
        endcase
    end

    always_comb
    begin
        edit_mode_next = edit_mode_reg;
        menu_pos_next  = menu_pos_reg;
        target_next    = target_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        cool_next      = cool_reg;
        heat_next      = heat_reg;
        temp_next      = temp_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        beep           = 1'b0;
        sel_next_value = sel_value;

        unique case (ev)
            EV_SAMPLE:
            begin
                temp_next = sample_temp;
                priority if (diff >= 11'sd3)
                begin
                    cool_next = 2'd2;
                    heat_next = 2'd0;
                end
                else if (diff >= 11'sd1)
                begin
                    cool_next = 2'd1;
                    heat_next = 2'd0;
                end
                else if (diff <= -11'sd3)
                begin
                    cool_next = 2'd0;
                    heat_next = 2'd2;
                end
                else if (diff <= -11'sd1)
                begin
                    cool_next = 2'd0;
                    heat_next = 2'd1;
                end
            end
            EV_OK:
            begin
                beep           = 1'b1;
                edit_mode_next = !edit_mode_reg;
            end
            EV_UP:
            begin
                beep = 1'b1;
                if (!edit_mode_reg)
                begin
                    menu_pos_next = (pos_inc >= (MENU_W+1)'(MENU_ENTRIES)) ? '0
                                                                           : pos_inc[MENU_W-1:0];
                end
                else if (sel_value < SETPOINT_MAX)
                begin
                    sel_next_value = sel_value + 1'b1;
                end
            end
            EV_DOWN:
            begin
                if (!edit_mode_reg)
                begin
                    beep          = 1'b1;
                    menu_pos_next = (menu_pos_reg == '0) ? MENU_W'(MENU_ENTRIES - 1)
                                                         : menu_pos_reg - 1'b1;
                end
                else if (sel_value != '0)
                begin
                    sel_next_value = sel_value - 1'b1;
                end
            end
            EV_TICK:
            begin
                if (sec_reg >= LAST_SEC_MIN)
                begin
                    sec_next = '0;
                    if (min_reg >= LAST_SEC_MIN)
                    begin
                        min_next  = '0;
                        hour_next = (hour_reg >= LAST_HOUR) ? '0 : hour_reg + 1'b1;
                    end
                    else
                    begin
                        min_next = min_reg + 1'b1;
                    end
                end
                else
                begin
                    sec_next = sec_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Entries past the three setpoints have a zero value and nothing to write back.
        unique case (menu_pos_reg)
            POS_TARGET: target_next = sel_next_value;
            POS_HIGH:   high_next   = sel_next_value;
            POS_LOW:    low_next    = sel_next_value;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.cooling_level   = cool_next;
        result.heating_level   = heat_next;
        result.alarm_on        = (temp_next > high_next) || (temp_next < low_next);
        result.beep            = beep;
        result.editing         = edit_mode_next;
        result.menu_item_index = menu_pos_next;
        unique case (menu_pos_next)
            POS_TARGET: result.edited_value = target_next;
            POS_HIGH:   result.edited_value = high_next;
            POS_LOW:    result.edited_value = low_next;
            default:    result.edited_value = '0;
        endcase
        result.temperature     = temp_next;
        result.hours           = hour_next;
        result.minutes         = min_next;
        result.seconds         = sec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_mode_reg <= 1'b0;
            menu_pos_reg  <= '0;
            target_reg    <= TARGET_RESET;
            high_reg      <= HIGH_RESET;
            low_reg       <= LOW_RESET;
            cool_reg      <= '0;
            heat_reg      <= '0;
            temp_reg      <= TEMP_RESET;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
        end
        else if (advance)
        begin
            edit_mode_reg <= edit_mode_next;
            menu_pos_reg  <= menu_pos_next;
            target_reg    <= target_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            cool_reg      <= cool_next;
            heat_reg      <= heat_next;
            temp_reg      <= temp_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
        end
    end

    a_menu_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        menu_pos_reg < MENU_W'(MENU_ENTRIES))
        else $error("menu position outside the menu");

    a_ok_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ev == EV_OK |=> edit_mode_reg != $past(edit_mode_reg))
        else $error("ok key did not toggle the edit layer");

    a_sec_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ev == EV_TICK && sec_reg == LAST_SEC_MIN |=> sec_reg == '0)
        else $error("seconds did not wrap");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(target_reg) && $stable(sec_reg) && $stable(menu_pos_reg))
        else $error("state changed without an event");
endmodule

/* sv/thst_out_reg.sv */
`timescale 1ns / 1ps

module thst_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                advance,
    input  thst_pkg::thst_rsp_t load_item,
    output logic                out_valid,
    input  logic                out_ready,
    output thst_pkg::thst_rsp_t out_item
);
    import thst_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    thst_rsp_t item_reg;

    assign advance = load_valid && (!valid_reg || out_ready);

    always_comb
    begin
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

/* sv/staged_thermostat_with_setpoint_menu_top.sv */
`timescale 1ns / 1ps

// An accepted beat is held in the input register; its result is loaded into the result
// register when that register can take it, and is offered on rsp from there.
// Throughput: one event per cycle; the input register feeds the state update and the
// result register in the same cycle, so the pipeline never bubbles without backpressure.
// Reset (rst_n low, asynchronous) empties both registers and restores the setpoints,
// stages, temperature and clock to their power-up values.
module staged_thermostat_with_setpoint_menu_top (
    input  logic              clk,
    input  logic              rst_n,
    thst_req_if.sink          req,
    thst_rsp_if.source        rsp
);
    import thst_pkg::*;

    thst_req_t in_item;
    thst_req_t held_item;
    thst_rsp_t core_result;
    thst_rsp_t out_item;
    logic      held_valid;
    logic      advance;

    assign in_item.req_type   = req.req_type;
    assign in_item.adc_sample = req.adc_sample;

    thst_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    thst_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (core_result)
    );

    thst_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .advance    (advance),
        .load_item  (core_result),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_item   (out_item)
    );

    assign rsp.cooling_level   = out_item.cooling_level;
    assign rsp.heating_level   = out_item.heating_level;
    assign rsp.alarm_on        = out_item.alarm_on;
    assign rsp.beep            = out_item.beep;
    assign rsp.editing         = out_item.editing;
    assign rsp.menu_item_index = out_item.menu_item_index;
    assign rsp.edited_value    = out_item.edited_value;
    assign rsp.temperature     = out_item.temperature;
    assign rsp.hours           = out_item.hours;
    assign rsp.minutes         = out_item.minutes;
    assign rsp.seconds         = out_item.seconds;
endmodule
